// ===== rtl/ip_prefix_counter_hash_table_top_defines.svh =====
// Assertion macros for the prefix counter hash table checker.
// Used by rtl/pch_checker.sv; needs clk and arst_n in the including scope.
`ifndef IP_PREFIX_COUNTER_HASH_TABLE_TOP_DEFINES_SVH
`define IP_PREFIX_COUNTER_HASH_TABLE_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PCH_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// next-cycle implication, disabled during reset
`define PCH_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

// ===== rtl/pch_pkg.sv =====
// Shared types, widths and constants of the prefix counter hash table.
// No dependencies; imported by every module of the block.
`default_nettype none

package pch_pkg;

	localparam int TABLE_DEPTH = 8192;
	localparam int PORT_COUNT  = 32;

	localparam int ADDR_W     = 32;
	localparam int LEN_W      = 16;
	localparam int PORT_W     = 5;
	localparam int SLOT_OUT_W = 13;
	localparam int PKT_W      = 32;
	localparam int BYTE_W     = 48;
	localparam int DIST_W     = 14;
	localparam int PREFIX_W   = 24;
	localparam int CRC_W      = 32;

	localparam int SLOT_W     = $clog2(TABLE_DEPTH);
	localparam int PORT_IDX_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;

	localparam logic [CRC_W-1:0] CRC_POLY  = 32'h82F6_3B78;
	localparam logic [CRC_W-1:0] HASH_MASK = 32'h0000_1FFF;
	localparam int HASH_W    = 13;
	localparam int HASH_SPAN = 8192;

	// home slot needs a mod reduction only when the table is smaller than the hash range
	localparam bit HOME_REDUCE = (TABLE_DEPTH < HASH_SPAN);
	localparam int MOD_STEPS   = HASH_W;
	localparam int MOD_CNT_W   = 4;

	localparam logic [1:0] CRC_OCTETS = 2'd3;

	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	typedef enum logic [1:0] {
		STATUS_HIT  = 2'd0,
		STATUS_NEW  = 2'd1,
		STATUS_FULL = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_MOD,
		ST_READ,
		ST_CHECK
	} state_t;

	typedef struct packed {
		logic [PREFIX_W-1:0] prefix;
		logic [PKT_W-1:0]    packets;
		logic [BYTE_W-1:0]   sum_bytes;
		logic [BYTE_W-1:0]   outbound_bytes;
		logic [BYTE_W-1:0]   inbound_bytes;
	} entry_t;

	typedef struct packed {
		logic              rd_en;
		logic [SLOT_W-1:0] rd_addr;
		logic              wr_en;
		logic [SLOT_W-1:0] wr_addr;
	} table_req_t;

endpackage

`default_nettype wire

// ===== rtl/ip_prefix_counter_hash_table_top.sv =====
// One request at a time: the prefix is hashed by the byte-serial CRC, reduced
// mod TABLE_DEPTH when the table is below 8192 slots, and probed linearly from
// the home slot; each probe is a memory read and compare, and a free or matching
// slot is written. Input stalls from accept until the result is registered.
// Reset: asynchronous; a clearing sweep of all TABLE_DEPTH slots follows, stalling input.
// Depends on pch_pkg, pch_crc, pch_table.
`default_nettype none

module ip_prefix_counter_hash_table_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [pch_pkg::ADDR_W-1:0]     server_address,
	input  wire logic                           outbound,
	input  wire logic [pch_pkg::LEN_W-1:0]      packet_length,
	input  wire logic [pch_pkg::PORT_W-1:0]     port_number,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic      [pch_pkg::SLOT_OUT_W-1:0] slot_index,
	output logic      [1:0]                     lookup_status,
	output logic      [pch_pkg::PKT_W-1:0]      entry_packets,
	output logic      [pch_pkg::BYTE_W-1:0]     entry_total_bytes,
	output logic      [pch_pkg::BYTE_W-1:0]     entry_outbound_bytes,
	output logic      [pch_pkg::BYTE_W-1:0]     entry_inbound_bytes,
	output logic      [pch_pkg::DIST_W-1:0]     distinct_prefixes
);
	import pch_pkg::*;

	state_t state_q, state_d;

	// captured request
	logic [PREFIX_W-1:0] prefix_q;
	logic                outbound_q;
	logic [LEN_W-1:0]    len_q;
	logic [PORT_W-1:0]   port_q;

	logic [SLOT_W-1:0]    slot_q, home_q, probe_cnt_q;
	logic [HASH_W-1:0]    h_q;
	logic [MOD_CNT_W-1:0] k_q;

	logic [DIST_W-1:0] ports_q [PORT_COUNT];

	logic                  out_valid_q;
	logic [SLOT_OUT_W-1:0] slot_index_q;
	status_t               status_q;
	logic [PKT_W-1:0]      packets_q;
	logic [BYTE_W-1:0]     total_q, outb_q, inb_q;
	logic [DIST_W-1:0]     distinct_q;

	logic             accept;
	logic [CRC_W-1:0] crc;
	logic             crc_done;
	table_req_t       tbl_req;
	entry_t           rd_data, wr_data;
	logic             clear_done;

	logic [HASH_W-1:0]   home13, h_step;
	logic [SLOT_W-1:0]   home_direct, slot_next;
	logic [CRC_W-1:0]    mod_sub;
	logic                empty, match, last, out_free, finish;
	logic                port_ok;
	logic [PORT_IDX_W-1:0] port_idx;
	logic [DIST_W-1:0]   port_cur, port_inc;

	function automatic logic [BYTE_W-1:0] sat_add(logic [BYTE_W-1:0] acc,
			logic [LEN_W-1:0] v);
		logic [BYTE_W:0] s;
		s = {1'b0, acc} + (BYTE_W+1)'(v);
		return s[BYTE_W] ? {BYTE_W{1'b1}} : s[BYTE_W-1:0];
	endfunction

	pch_crc u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.prefix (server_address[ADDR_W-1 -: PREFIX_W]),
		.crc    (crc),
		.done   (crc_done)
	);

	pch_table u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (tbl_req),
		.wr_data    (wr_data),
		.rd_data    (rd_data),
		.clear_done (clear_done)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	assign home13      = HASH_W'(crc & HASH_MASK);
	assign home_direct = SLOT_W'(home13);
	assign slot_next   = (slot_q == SLOT_W'(TABLE_DEPTH - 1)) ? '0 : slot_q + SLOT_W'(1);

	// restoring reduction: subtract TABLE_DEPTH << k when it fits
	assign mod_sub = CRC_W'(TABLE_DEPTH) << k_q;
	assign h_step  = (CRC_W'(h_q) >= mod_sub) ? HASH_W'(CRC_W'(h_q) - mod_sub) : h_q;

	assign empty    = (rd_data.packets == '0);
	assign match    = (rd_data.prefix == prefix_q);
	assign last     = (probe_cnt_q == SLOT_W'(TABLE_DEPTH - 1));
	assign out_free = !out_valid_q || !out_stall;

	assign port_ok  = (32'(port_q) < PORT_COUNT);
	assign port_idx = PORT_IDX_W'(port_q);
	assign port_cur = port_ok ? ports_q[port_idx] : '0;
	assign port_inc = (port_cur != DIST_MAX) ? port_cur + DIST_W'(1) : port_cur;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clear_done) state_d = ST_IDLE;
			ST_IDLE:  if (in_valid) state_d = ST_HASH;
			ST_HASH: begin
				if (crc_done) state_d = HOME_REDUCE ? ST_MOD : ST_CHECK;
			end
			ST_MOD:   if (k_q == '0) state_d = ST_READ;
			ST_READ:  state_d = ST_CHECK;
			ST_CHECK: if (finish) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// memory requests and entry update
	always_comb begin
		tbl_req.rd_en   = 1'b0;
		tbl_req.rd_addr = slot_q;
		tbl_req.wr_en   = 1'b0;
		tbl_req.wr_addr = slot_q;
		finish          = 1'b0;

		wr_data.prefix         = prefix_q;
		wr_data.packets        = (rd_data.packets != '1) ? rd_data.packets + PKT_W'(1)
		                                                 : rd_data.packets;
		wr_data.sum_bytes      = sat_add(rd_data.sum_bytes, len_q);
		wr_data.outbound_bytes = outbound_q ? sat_add(rd_data.outbound_bytes, len_q)
		                                    : rd_data.outbound_bytes;
		wr_data.inbound_bytes  = outbound_q ? rd_data.inbound_bytes
		                                    : sat_add(rd_data.inbound_bytes, len_q);

		case (state_q)
			ST_HASH: begin
				if (crc_done && !HOME_REDUCE) begin
					tbl_req.rd_en   = 1'b1;
					tbl_req.rd_addr = home_direct;
				end
			end
			ST_READ: tbl_req.rd_en = 1'b1;
			ST_CHECK: begin
				if (empty || match || last) begin
					// hold the result until the output register is free
					finish        = out_free;
					tbl_req.wr_en = out_free && (empty || match);
				end else begin
					tbl_req.rd_en   = 1'b1;
					tbl_req.rd_addr = slot_next;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
			probe_cnt_q <= '0;
			k_q         <= '0;
			for (int i = 0; i < PORT_COUNT; i++) begin
				ports_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_HASH: begin
					probe_cnt_q <= '0;
					k_q         <= MOD_CNT_W'(MOD_STEPS - 1);
				end
				ST_MOD: k_q <= k_q - MOD_CNT_W'(1);
				ST_CHECK: begin
					if (!(empty || match || last)) begin
						probe_cnt_q <= probe_cnt_q + SLOT_W'(1);
					end
				end
				default: ;
			endcase
			if (finish && empty && port_ok) begin
				ports_q[port_idx] <= port_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prefix_q   <= server_address[ADDR_W-1 -: PREFIX_W];
			outbound_q <= outbound;
			len_q      <= packet_length;
			port_q     <= port_number;
		end
		case (state_q)
			ST_HASH: begin
				slot_q <= home_direct;
				home_q <= home_direct;
				h_q    <= home13;
			end
			ST_MOD: begin
				h_q <= h_step;
				if (k_q == '0) begin
					slot_q <= SLOT_W'(h_step);
					home_q <= SLOT_W'(h_step);
				end
			end
			ST_CHECK: begin
				if (!(empty || match || last)) begin
					slot_q <= slot_next;
				end
			end
			default: ;
		endcase
		if (finish) begin
			if (empty || match) begin
				slot_index_q <= SLOT_OUT_W'(slot_q);
				status_q     <= empty ? STATUS_NEW : STATUS_HIT;
				packets_q    <= wr_data.packets;
				total_q      <= wr_data.sum_bytes;
				outb_q       <= wr_data.outbound_bytes;
				inb_q        <= wr_data.inbound_bytes;
				distinct_q   <= (empty && port_ok) ? port_inc : port_cur;
			end else begin
				slot_index_q <= SLOT_OUT_W'(home_q);
				status_q     <= STATUS_FULL;
				packets_q    <= '0;
				total_q      <= '0;
				outb_q       <= '0;
				inb_q        <= '0;
				distinct_q   <= port_cur;
			end
		end
	end

	assign out_valid            = out_valid_q;
	assign slot_index           = slot_index_q;
	assign lookup_status        = status_q;
	assign entry_packets        = packets_q;
	assign entry_total_bytes    = total_q;
	assign entry_outbound_bytes = outb_q;
	assign entry_inbound_bytes  = inb_q;
	assign distinct_prefixes    = distinct_q;

endmodule

`default_nettype wire

// ===== rtl/pch_crc.sv =====
// Byte-serial CRC with the reflected CRC32C polynomial, zero start value and no final
// inversion, over the three prefix octets, one octet per cycle. Depends on pch_pkg.
`default_nettype none

module pch_crc (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [pch_pkg::PREFIX_W-1:0] prefix,
	output logic      [pch_pkg::CRC_W-1:0]    crc,
	output logic                              done
);
	import pch_pkg::*;

	logic [CRC_W-1:0]    crc_q;
	logic [PREFIX_W-1:0] sh_q;
	logic [1:0]          count_q;

	function automatic logic [CRC_W-1:0] crc_byte(logic [CRC_W-1:0] c, logic [7:0] b);
		logic [CRC_W-1:0] r;
		r = c ^ {{(CRC_W-8){1'b0}}, b};
		for (int i = 0; i < 8; i++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (start) begin
			count_q <= CRC_OCTETS;
		end else if (count_q != '0) begin
			count_q <= count_q - 2'd1;
		end
	end

	// first octet sits in the top byte of the prefix
	always_ff @(posedge clk) begin
		if (start) begin
			crc_q <= '0;
			sh_q  <= prefix;
		end else if (count_q != '0) begin
			crc_q <= crc_byte(crc_q, sh_q[PREFIX_W-1 -: 8]);
			sh_q  <= {sh_q[PREFIX_W-9:0], 8'h00};
		end
	end

	assign crc  = crc_q;
	assign done = (count_q == '0);

endmodule

`default_nettype wire

// ===== rtl/pch_table.sv =====
// Slot memory of the hash table with its post-reset clearing sweep.
// Depends on pch_pkg; one write and one registered read per cycle, requested writes being ignored during the sweep.
`default_nettype none

module pch_table (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire pch_pkg::table_req_t   req,
	input  wire pch_pkg::entry_t       wr_data,
	output pch_pkg::entry_t            rd_data,
	output logic                       clear_done
);
	import pch_pkg::*;

	entry_t            mem [TABLE_DEPTH];
	entry_t            rd_data_q;
	logic              clearing_q;
	logic [SLOT_W-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + SLOT_W'(1);
			if (clr_addr_q == SLOT_W'(TABLE_DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_addr_q] <= '0;
		end else if (req.wr_en) begin
			mem[req.wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_addr];
		end
	end

	assign rd_data    = rd_data_q;
	assign clear_done = !clearing_q;

endmodule

`default_nettype wire

// ===== rtl/pch_checker.sv =====
// Port-level checks for the prefix counter hash table, bound to the top level.
// Depends on pch_pkg and ip_prefix_counter_hash_table_top_defines.svh.
`default_nettype none

`include "ip_prefix_counter_hash_table_top_defines.svh"

module pch_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           in_valid,
	input wire logic                           in_stall,
	input wire logic                           out_valid,
	input wire logic                           out_stall,
	input wire logic [pch_pkg::SLOT_OUT_W-1:0] slot_index,
	input wire logic [1:0]                     lookup_status,
	input wire logic [pch_pkg::PKT_W-1:0]      entry_packets,
	input wire logic [pch_pkg::BYTE_W-1:0]     entry_total_bytes
);
	import pch_pkg::*;

	// a stalled result stays put
	`PCH_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(slot_index) && $stable(entry_packets))

	// one request at a time: input stalls right after an accept
	`PCH_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

	// a dropped packet reports cleared counters
	`PCH_ASSERT_NOW(a_full_zero, out_valid && (lookup_status == STATUS_FULL),
		(entry_packets == '0) && (entry_total_bytes == '0))

	// a fresh entry holds exactly one packet
	`PCH_ASSERT_NOW(a_new_one, out_valid && (lookup_status == STATUS_NEW),
		entry_packets == PKT_W'(1))

endmodule

bind ip_prefix_counter_hash_table_top pch_checker u_pch_checker (.*);

`default_nettype wire

// ===== sim/ip_prefix_counter_hash_table_top_tb.sv =====
// Self-checking testbench for the /24 prefix counter hash table: directed and
// random traffic with collisions and wrap-around, checked against an in-bench table model.
// Depends on pch_pkg and ip_prefix_counter_hash_table_top.
`timescale 1ns / 100ps

module ip_prefix_counter_hash_table_top_tb;
	import pch_pkg::*;

	localparam int IDLE_LIMIT  = 50000;	// longer than the clearing sweep after reset
	localparam int TAIL_CYCLES = 32;
	localparam int REPORT_CAP  = 100;
	localparam int RANDOM_REQS = 1734;

	typedef struct packed {
		logic [SLOT_OUT_W-1:0] slot;
		status_t               status;
		logic [PKT_W-1:0]      packets;
		logic [BYTE_W-1:0]     total;
		logic [BYTE_W-1:0]     outb;
		logic [BYTE_W-1:0]     inb;
		logic [DIST_W-1:0]     port_total;
	} lookup_result_t;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [ADDR_W-1:0]     server_address = '0;
	logic                  outbound = 1'b0;
	logic [LEN_W-1:0]      packet_length = '0;
	logic [PORT_W-1:0]     port_number = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [SLOT_OUT_W-1:0] slot_index;
	logic [1:0]            lookup_status;
	logic [PKT_W-1:0]      entry_packets;
	logic [BYTE_W-1:0]     entry_total_bytes;
	logic [BYTE_W-1:0]     entry_outbound_bytes;
	logic [BYTE_W-1:0]     entry_inbound_bytes;
	logic [DIST_W-1:0]     distinct_prefixes;

	ip_prefix_counter_hash_table_top dut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.in_valid             (in_valid),
		.in_stall             (in_stall),
		.server_address       (server_address),
		.outbound             (outbound),
		.packet_length        (packet_length),
		.port_number          (port_number),
		.out_valid            (out_valid),
		.out_stall            (out_stall),
		.slot_index           (slot_index),
		.lookup_status        (lookup_status),
		.entry_packets        (entry_packets),
		.entry_total_bytes    (entry_total_bytes),
		.entry_outbound_bytes (entry_outbound_bytes),
		.entry_inbound_bytes  (entry_inbound_bytes),
		.distinct_prefixes    (distinct_prefixes)
	);

	always #6 clk = ~clk;

	// table model
	logic [PREFIX_W-1:0] model_prefix   [TABLE_DEPTH];
	logic [PKT_W-1:0]    model_packets  [TABLE_DEPTH];
	logic [BYTE_W-1:0]   model_total    [TABLE_DEPTH];
	logic [BYTE_W-1:0]   model_outbound [TABLE_DEPTH];
	logic [BYTE_W-1:0]   model_inbound  [TABLE_DEPTH];
	logic [DIST_W-1:0]   model_port_prefixes [PORT_COUNT];

	// two prefixes per home slot, for collisions
	logic [PREFIX_W-1:0] home_first  [TABLE_DEPTH];
	logic [PREFIX_W-1:0] home_second [TABLE_DEPTH];
	logic [1:0]          home_found  [TABLE_DEPTH];

	lookup_result_t      expected_lookups[$];
	logic [PREFIX_W-1:0] prefix_pool[$];

	int error_count = 0;
	int sent_count = 0;
	int hit_count = 0;
	int new_count = 0;
	int full_count = 0;
	int burst_left = 0;
	int idle_cycles = 0;
	int stall_tick = 0;
	stall_mode_t stall_mode = STALL_NONE;

	function automatic logic [SLOT_W-1:0] home_of(input logic [PREFIX_W-1:0] prefix);
		logic [CRC_W-1:0] crc;
		crc = '0;
		for (int o = 2; o >= 0; o--) begin
			crc ^= CRC_W'(prefix[o*8 +: 8]);
			for (int b = 0; b < 8; b++)
				crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
		end
		return SLOT_W'((crc & HASH_MASK) % TABLE_DEPTH);
	endfunction

	function automatic logic [BYTE_W-1:0] add_bytes_sat(input logic [BYTE_W-1:0] acc,
			input logic [LEN_W-1:0] len);
		logic [BYTE_W:0] sum;
		sum = {1'b0, acc} + len;
		return sum[BYTE_W] ? {BYTE_W{1'b1}} : sum[BYTE_W-1:0];
	endfunction

	// probe, update the model and return the result the block should give
	function automatic lookup_result_t predict_lookup(input logic [ADDR_W-1:0] addr,
			input logic dir_out, input logic [LEN_W-1:0] len, input logic [PORT_W-1:0] port);
		lookup_result_t r;
		logic [PREFIX_W-1:0] prefix;
		logic [SLOT_W-1:0] home;
		logic [SLOT_W-1:0] s;
		bit found;
		bit port_ok;
		status_t st;
		prefix = addr[31:8];
		home = home_of(prefix);
		port_ok = port < PORT_COUNT;
		found = 1'b0;
		st = STATUS_FULL;
		s = home;
		r = '0;
		for (int n = 0; n < TABLE_DEPTH && !found; n++) begin
			s = SLOT_W'((home + n) % TABLE_DEPTH);
			if (model_packets[s] == '0) begin
				found = 1'b1;
				st = STATUS_NEW;
			end else if (model_prefix[s] == prefix) begin
				found = 1'b1;
				st = STATUS_HIT;
			end
		end
		r.status = st;
		if (!found) begin
			r.slot = SLOT_OUT_W'(home);
			r.port_total = port_ok ? model_port_prefixes[port] : '0;
			return r;
		end
		if (st == STATUS_NEW) begin
			model_prefix[s] = prefix;
			if (port_ok && model_port_prefixes[port] != DIST_MAX)
				model_port_prefixes[port]++;
		end
		if (model_packets[s] != {PKT_W{1'b1}})
			model_packets[s]++;
		model_total[s] = add_bytes_sat(model_total[s], len);
		if (dir_out)
			model_outbound[s] = add_bytes_sat(model_outbound[s], len);
		else
			model_inbound[s] = add_bytes_sat(model_inbound[s], len);
		r.slot    = SLOT_OUT_W'(s);
		r.packets = model_packets[s];
		r.total   = model_total[s];
		r.outb    = model_outbound[s];
		r.inb     = model_inbound[s];
		r.port_total = port_ok ? model_port_prefixes[port] : '0;
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		if (error_count < REPORT_CAP)
			$display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h",
				$time, field, got, want);
		error_count++;
	endtask

	// bursts of requests separated by random gaps; predicts on acceptance
	task automatic send_request(input logic [ADDR_W-1:0] addr, input logic dir_out,
			input logic [LEN_W-1:0] len, input logic [PORT_W-1:0] port);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
		end
		burst_left--;
		in_valid       <= 1'b1;
		server_address <= addr;
		outbound       <= dir_out;
		packet_length  <= len;
		port_number    <= port;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_lookups.push_back(predict_lookup(addr, dir_out, len, port));
		sent_count++;
	endtask

	task automatic wait_for_drain();
		in_valid <= 1'b0;
		burst_left = 0;
		while (expected_lookups.size() != 0) @(posedge clk);
	endtask

	function automatic logic [LEN_W-1:0] pick_length();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return LEN_W'($urandom);
	endfunction

	task automatic build_home_candidates();
		int covered;
		covered = 0;
		for (int h = 0; h < TABLE_DEPTH; h++)
			home_found[h] = '0;
		for (int unsigned p = 0; p < (1 << PREFIX_W) && covered < TABLE_DEPTH; p++) begin
			logic [SLOT_W-1:0] h;
			h = home_of(PREFIX_W'(p));
			if (home_found[h] == 2'd0) begin
				home_first[h] = PREFIX_W'(p);
				home_found[h] = 2'd1;
			end else if (home_found[h] == 2'd1) begin
				home_second[h] = PREFIX_W'(p);
				home_found[h] = 2'd2;
				covered++;
			end
		end
	endtask

	task automatic test_directed();
		// all-zero and all-ones addresses, last octet must not matter
		send_request(32'h0000_0000, 1'b0, 16'h0000, 5'd0);
		send_request(32'h0000_00FF, 1'b1, 16'hFFFF, 5'd31);
		send_request(32'hFFFF_FFFF, 1'b1, 16'hFFFF, 5'd31);
		send_request(32'hFFFF_FF00, 1'b0, 16'h0001, 5'd0);
		// two prefixes on one home slot, then hit the displaced one
		send_request({home_first[100], 8'h12}, 1'b0, 16'h1234, 5'd10);
		send_request({home_second[100], 8'h34}, 1'b1, 16'h8000, 5'd21);
		send_request({home_second[100], 8'hCD}, 1'b0, 16'h7FFF, 5'd21);
		// cluster at the top of the table wraps to slot 0 and beyond
		send_request({home_first[TABLE_DEPTH-2], 8'h00}, 1'b1, 16'h00FF, 5'd5);
		send_request({home_first[TABLE_DEPTH-1], 8'h01}, 1'b0, 16'hFF00, 5'd26);
		send_request({home_second[TABLE_DEPTH-2], 8'h02}, 1'b1, 16'h5555, 5'd15);
		send_request({home_second[TABLE_DEPTH-1], 8'h03}, 1'b0, 16'hAAAA, 5'd16);
		send_request({home_second[TABLE_DEPTH-2], 8'hF0}, 1'b0, 16'h0F0F, 5'd1);
		send_request({home_second[TABLE_DEPTH-1], 8'h0F}, 1'b1, 16'hF0F0, 5'd30);
		send_request({home_first[0], 8'h77}, 1'b1, 16'h0002, 5'd0);
		send_request(32'hFFFF_FF80, 1'b1, 16'hFFFF, 5'd31);
		send_request(32'h8000_0000, 1'b0, 16'h4000, 5'd16);
	endtask

	task automatic test_random_traffic();
		logic [PREFIX_W-1:0] prefix;
		logic [SLOT_W-1:0] h;
		int r;
		for (int i = 0; i < 32; i++)
			prefix_pool.push_back(PREFIX_W'($urandom));
		for (int i = 0; i < RANDOM_REQS; i++) begin
			if (i == RANDOM_REQS / 2)
				wait_for_drain();
			r = $urandom_range(0, 99);
			if (r < 55) begin
				prefix = prefix_pool[$urandom_range(0, prefix_pool.size() - 1)];
			end else if (r < 75) begin
				// keys homed on both sides of the wrap point build long probe chains
				h = SLOT_W'(TABLE_DEPTH - 4 + $urandom_range(0, 7));
				prefix = $urandom_range(0, 1) ? home_first[h] : home_second[h];
			end else if (r < 90) begin
				prefix = PREFIX_W'($urandom);
				if (prefix_pool.size() < 96)
					prefix_pool.push_back(prefix);
			end else begin
				prefix = prefix_pool[$urandom_range(0, prefix_pool.size() - 1)];
				prefix ^= PREFIX_W'(1) << $urandom_range(0, PREFIX_W - 1);
			end
			send_request({prefix, 8'($urandom)}, 1'($urandom), pick_length(),
				PORT_W'($urandom));
		end
	endtask

	task automatic finish_run();
		int occupied;
		wait_for_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		occupied = 0;
		for (int h = 0; h < TABLE_DEPTH; h++)
			if (model_packets[h] != '0)
				occupied++;
		$display("covered %0d requests: %0d hits, %0d new entries, %0d dropped as table full",
			sent_count, hit_count, new_count, full_count);
		$display("model occupancy at end: %0d of %0d slots; %0d mismatches",
			occupied, TABLE_DEPTH, error_count);
		if (error_count == 0)
			$display("ip_prefix_counter_hash_table_top_tb passed");
		else
			$display("ip_prefix_counter_hash_table_top_tb failed");
		$finish;
	endtask

	// result check, receiver stall pattern and watchdog
	always @(posedge clk) begin : result_check
		lookup_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_lookups.size() == 0) begin
				report_mismatch("unexpected result, slot", 64'(slot_index), 64'd0);
			end else begin
				want = expected_lookups.pop_front();
				case (want.status)
					STATUS_HIT: hit_count++;
					STATUS_NEW: new_count++;
					default:    full_count++;
				endcase
				if (slot_index !== want.slot)
					report_mismatch("slot_index", 64'(slot_index), 64'(want.slot));
				if (lookup_status !== want.status)
					report_mismatch("lookup_status", 64'(lookup_status), 64'(want.status));
				if (entry_packets !== want.packets)
					report_mismatch("entry_packets", 64'(entry_packets), 64'(want.packets));
				if (entry_total_bytes !== want.total)
					report_mismatch("entry_total_bytes", 64'(entry_total_bytes),
						64'(want.total));
				if (entry_outbound_bytes !== want.outb)
					report_mismatch("entry_outbound_bytes", 64'(entry_outbound_bytes),
						64'(want.outb));
				if (entry_inbound_bytes !== want.inb)
					report_mismatch("entry_inbound_bytes", 64'(entry_inbound_bytes),
						64'(want.inb));
				if (distinct_prefixes !== want.port_total)
					report_mismatch("distinct_prefixes", 64'(distinct_prefixes),
						64'(want.port_total));
			end
		end

		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
				IDLE_LIMIT, expected_lookups.size());
			$display("ip_prefix_counter_hash_table_top_tb failed");
			$finish;
		end

		stall_tick++;
		if (stall_tick % 150 == 0)
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
		case (stall_mode)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
			default:     out_stall <= (stall_tick % 5 < 3);
		endcase
	end

	initial begin
		for (int h = 0; h < TABLE_DEPTH; h++) begin
			model_prefix[h]   = '0;
			model_packets[h]  = '0;
			model_total[h]    = '0;
			model_outbound[h] = '0;
			model_inbound[h]  = '0;
		end
		for (int p = 0; p < PORT_COUNT; p++)
			model_port_prefixes[p] = '0;
		build_home_candidates();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random_traffic();
		finish_run();
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/pch_pkg.sv
rtl/pch_crc.sv
rtl/pch_table.sv
rtl/ip_prefix_counter_hash_table_top.sv
rtl/pch_checker.sv
sim/ip_prefix_counter_hash_table_top_tb.sv
